[sv/acs_pkg.sv]
`default_nettype none

package acs_pkg;

  // Number of converter channels that are handled.
  localparam int unsigned CHANNELS = 8;
  localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Fixed field widths of the request and result items.
  localparam int unsigned NUM_WORDS = 8;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned BYTE_W    = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_DATA  = 2'd2;

  // Reset value of the channel mask: channel 0 only.
  localparam logic [MASK_W-1:0] MASK_RESET = 8'h01;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_start;
    logic do_overrun;
    logic do_strobe;
    logic do_data;
    logic emit_sample;
    logic emit_empty;
  } acs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pending;
    logic frames_zero;
    logic rem_zero;
    logic rem_single;
    logic out_free;
  } acs_sts_t;

  // Reverses the bit order of the low byte and keeps the high byte.
  function automatic logic [WORD_W-1:0] fix_low_byte(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] r;
    r = w;
    for (int b = 0; b < BYTE_W; b++) begin
      r[b] = w[BYTE_W-1-b];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/acs_req_if.sv]
`default_nettype none

interface acs_req_if;
  import acs_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [FRAME_W-1:0]  frame_count;
  logic [WORD_W-1:0]   raw_word_0;
  logic [WORD_W-1:0]   raw_word_1;
  logic [WORD_W-1:0]   raw_word_2;
  logic [WORD_W-1:0]   raw_word_3;
  logic [WORD_W-1:0]   raw_word_4;
  logic [WORD_W-1:0]   raw_word_5;
  logic [WORD_W-1:0]   raw_word_6;
  logic [WORD_W-1:0]   raw_word_7;

  modport source (
    output valid, operation, frame_count,
    output raw_word_0, raw_word_1, raw_word_2, raw_word_3,
    output raw_word_4, raw_word_5, raw_word_6, raw_word_7,
    input  ready
  );

  modport sink (
    input  valid, operation, frame_count,
    input  raw_word_0, raw_word_1, raw_word_2, raw_word_3,
    input  raw_word_4, raw_word_5, raw_word_6, raw_word_7,
    output ready
  );

endinterface

`default_nettype wire

[sv/acs_rsp_if.sv]
`default_nettype none

interface acs_rsp_if;
  import acs_pkg::*;

  logic               valid;
  logic               ready;
  logic               start_conversion;
  logic               sample_valid;
  logic [WORD_W-1:0]  sample_value;
  logic [IDX_W-1:0]   channel_index;
  logic               last_of_frame;
  logic               run_done;
  logic               overrun;

  modport source (
    output valid, start_conversion, sample_valid, sample_value,
    output channel_index, last_of_frame, run_done, overrun,
    input  ready
  );

  modport sink (
    input  valid, start_conversion, sample_valid, sample_value,
    input  channel_index, last_of_frame, run_done, overrun,
    output ready
  );

endinterface

`default_nettype wire

[sv/acs_cfg_if.sv]
`default_nettype none

interface acs_cfg_if;
  import acs_pkg::*;

  logic               valid;
  logic               ready;
  logic [MASK_W-1:0]  data;

  modport source (
    output valid, data,
    input  ready
  );

  modport sink (
    input  valid, data,
    output ready
  );

endinterface

`default_nettype wire

[sv/acs_ctrl.sv]
`default_nettype none

module acs_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    req_valid_i,
  input  wire logic [acs_pkg::OP_W-1:0] req_op_i,
  output logic                         req_ready_o,
  input  wire acs_pkg::acs_sts_t       sts_i,
  output acs_pkg::acs_cmd_t            cmd_o
);
  import acs_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_q, state_d;
  logic accept;

  // Requests are taken only when idle and the result register can take a new result.
  assign req_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_op_i)
            OP_START: begin
              cmd_o.do_start = 1'b1;
            end
            OP_TICK: begin
              if (sts_i.pending) begin
                cmd_o.do_overrun = 1'b1;
              end else if (!sts_i.frames_zero) begin
                cmd_o.do_strobe = 1'b1;
              end
            end
            OP_DATA: begin
              if (sts_i.pending) begin
                cmd_o.do_data = 1'b1;
                state_d       = ST_EMIT;
              end
            end
            default: begin
              // The unused code is dropped without any effect.
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          if (sts_i.rem_zero) begin
            cmd_o.emit_empty = 1'b1;
            state_d          = ST_IDLE;
          end else begin
            cmd_o.emit_sample = 1'b1;
            if (sts_i.rem_single) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[sv/acs_datapath.sv]
`default_nettype none

module acs_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire acs_pkg::acs_cmd_t             cmd_i,
  output acs_pkg::acs_sts_t                  sts_o,
  input  wire logic [acs_pkg::FRAME_W-1:0]   frame_count_i,
  input  wire logic [acs_pkg::WORD_W-1:0]    raw_words_i [acs_pkg::NUM_WORDS],
  input  wire logic                          cfg_write_i,
  input  wire logic [acs_pkg::MASK_W-1:0]    cfg_data_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_start_conversion_o,
  output logic                               out_sample_valid_o,
  output logic [acs_pkg::WORD_W-1:0]         out_sample_value_o,
  output logic [acs_pkg::IDX_W-1:0]          out_channel_index_o,
  output logic                               out_last_of_frame_o,
  output logic                               out_run_done_o,
  output logic                               out_overrun_o
);
  import acs_pkg::*;

  // Run state.
  logic [FRAME_W-1:0]  frames_left_q;
  logic                pending_q;
  logic                overrun_q;
  logic [MASK_W-1:0]   mask_q;

  // Frame being emitted.
  logic [WORD_W-1:0]   raw_q [CHANNELS];
  logic [CHANNELS-1:0] rem_q;
  logic                done_q;

  // Result register.
  logic                valid_q;
  logic                start_conversion_q;
  logic                sample_valid_q;
  logic [WORD_W-1:0]   sample_value_q;
  logic [IDX_W-1:0]    channel_index_q;
  logic                last_of_frame_q;
  logic                run_done_q;
  logic                overrun_out_q;

  logic [CHANNELS-1:0] low_bit;
  logic [CHANNELS-1:0] rem_next;
  logic [CH_W-1:0]     sel_idx;
  logic                load;

  assign low_bit  = rem_q & (~rem_q + 1'b1);
  assign rem_next = rem_q & ~low_bit;

  // Lowest enabled channel still to be sent.
  always_comb begin
    sel_idx = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (rem_q[c]) begin
        sel_idx = CH_W'(c);
      end
    end
  end

  assign load = cmd_i.do_strobe || cmd_i.emit_sample || cmd_i.emit_empty;

  assign sts_o.pending     = pending_q;
  assign sts_o.frames_zero = (frames_left_q == '0);
  assign sts_o.rem_zero    = (rem_q == '0);
  assign sts_o.rem_single  = (rem_q != '0) && (rem_next == '0);
  assign sts_o.out_free    = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_left_q <= '0;
      pending_q     <= 1'b0;
      overrun_q     <= 1'b0;
      mask_q        <= MASK_RESET;
      rem_q         <= '0;
      valid_q       <= 1'b0;
    end else begin
      if (cfg_write_i) begin
        mask_q <= cfg_data_i;
      end
      if (cmd_i.do_start) begin
        frames_left_q <= frame_count_i;
        overrun_q     <= 1'b0;
      end
      if (cmd_i.do_overrun) begin
        overrun_q <= 1'b1;
      end
      if (cmd_i.do_strobe) begin
        pending_q <= 1'b1;
      end
      if (cmd_i.do_data) begin
        pending_q <= 1'b0;
        rem_q     <= mask_q[CHANNELS-1:0];
        if (frames_left_q != '0) begin
          frames_left_q <= frames_left_q - 1'b1;
        end
      end
      if (cmd_i.emit_sample) begin
        rem_q <= rem_next;
      end
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_data) begin
      done_q <= (frames_left_q == FRAME_W'(1));
      for (int c = 0; c < CHANNELS; c++) begin
        raw_q[c] <= raw_words_i[c];
      end
    end
    if (load) begin
      start_conversion_q <= cmd_i.do_strobe;
      sample_valid_q     <= cmd_i.emit_sample;
      sample_value_q     <= cmd_i.emit_sample ? fix_low_byte(raw_q[sel_idx]) : '0;
      channel_index_q    <= cmd_i.emit_sample ? IDX_W'(sel_idx) : '0;
      last_of_frame_q    <= cmd_i.emit_empty || (cmd_i.emit_sample && rem_next == '0);
      run_done_q         <= (cmd_i.emit_empty || (cmd_i.emit_sample && rem_next == '0))
                            && done_q;
      overrun_out_q      <= overrun_q;
    end
  end

  assign out_valid_o            = valid_q;
  assign out_start_conversion_o = start_conversion_q;
  assign out_sample_valid_o     = sample_valid_q;
  assign out_sample_value_o     = sample_value_q;
  assign out_channel_index_o    = channel_index_q;
  assign out_last_of_frame_o    = last_of_frame_q;
  assign out_run_done_o         = run_done_q;
  assign out_overrun_o          = overrun_out_q;

  a_strobe_sets_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_strobe |=> pending_q)
    else $error("strobe did not mark a conversion pending");

  a_data_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_data |=> !pending_q)
    else $error("data did not clear the pending conversion");

  a_sample_clears_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_sample |=> ($countones(rem_q) + 1) == $past($countones(rem_q)))
    else $error("sample emission did not retire exactly one channel");

  a_empty_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_empty |-> (rem_q == '0))
    else $error("empty frame result issued with channels still pending");

  a_frames_never_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cmd_i.do_start) |-> frames_left_q <= $past(frames_left_q))
    else $error("frame counter grew without a start request");

endmodule

`default_nettype wire

[sv/adc_capture_sequencer_core.sv]
`default_nettype none

// Capture-run sequencer for an eight-channel parallel converter. A start request loads
// the number of frames to capture and clears the overrun flag; it produces no result.
// A tick request either flags an overrun (a conversion is still pending), does nothing
// (no frames remain), or produces one result with start_conversion set and marks a
// conversion pending. A data request that arrives while a conversion is pending counts
// the frame down, clears the pending mark and produces one result per channel enabled in
// the channel mask, in ascending channel order, with the low byte of each raw word
// bit-reversed; the final result of the frame has last_of_frame set, and run_done when it
// ended the run. With an empty mask a data request still produces one result that only
// marks the end of the frame. A data request is first captured; its results then leave
// through a single result register, one per cycle while the result side does not stall.
// A new request is taken only while no frame is being sent and the result register is
// free or being drained. The channel mask register accepts a write in every cycle and
// should be written only while the block is idle.
module adc_capture_sequencer_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  acs_req_if.sink   req_i,
  acs_rsp_if.source rsp_o,
  acs_cfg_if.sink   cfg_i
);
  import acs_pkg::*;

  acs_cmd_t    cmd;
  acs_sts_t    sts;
  logic [WORD_W-1:0] raw_words [NUM_WORDS];

  // The mask register is a plain flop, so a write is always taken.
  assign cfg_i.ready = 1'b1;

  // Gather the request's bus words so the datapath can index them by channel.
  assign raw_words[0] = req_i.raw_word_0;
  assign raw_words[1] = req_i.raw_word_1;
  assign raw_words[2] = req_i.raw_word_2;
  assign raw_words[3] = req_i.raw_word_3;
  assign raw_words[4] = req_i.raw_word_4;
  assign raw_words[5] = req_i.raw_word_5;
  assign raw_words[6] = req_i.raw_word_6;
  assign raw_words[7] = req_i.raw_word_7;

  // The controller decodes requests and walks the frame; it drives the request ready.
  acs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the run state, the captured frame and the result register.
  acs_datapath u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .frame_count_i          (req_i.frame_count),
    .raw_words_i            (raw_words),
    .cfg_write_i            (cfg_i.valid),
    .cfg_data_i             (cfg_i.data),
    .out_ready_i            (rsp_o.ready),
    .out_valid_o            (rsp_o.valid),
    .out_start_conversion_o (rsp_o.start_conversion),
    .out_sample_valid_o     (rsp_o.sample_valid),
    .out_sample_value_o     (rsp_o.sample_value),
    .out_channel_index_o    (rsp_o.channel_index),
    .out_last_of_frame_o    (rsp_o.last_of_frame),
    .out_run_done_o         (rsp_o.run_done),
    .out_overrun_o          (rsp_o.overrun)
  );

endmodule

`default_nettype wire
